[rtl/core/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types and constants of the array table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ate_pkg;

  localparam int DEPTH   = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int CAP_W   = 5;
  localparam int FIDX_W  = 4;
  localparam int COUNT_W = 5;
  localparam int LW      = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam int PW      = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int SW      = CW + 1;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_GET     = 3'd3,
    OP_SET     = 3'd4,
    OP_SORTED  = 3'd5,
    OP_BSEARCH = 3'd6,
    OP_LSEARCH = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADIDX   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } stat_e;

  typedef struct packed {
    op_e                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] operand;
  } ate_in_t;

  typedef struct packed {
    stat_e                   status;
    logic signed [VAL_W-1:0] read_value;
    logic [FIDX_W-1:0]       found_index;
    logic [COUNT_W-1:0]      count;
  } ate_out_t;

endpackage

[rtl/core/array_table_engine.sv]
// ----------------------------------------------------------------------------
// array_table_engine
// Bounded table of signed 32-bit entries held in one RAM with a count of the
// entries in use. Each input item is one request (append, insert, delete, get,
// set, sorted insert, binary search, linear search with transposition) and
// gives exactly one result item with status, value, index and the new count.
// One request is worked at a time; the next item is taken while the previous
// result still waits at the output. All table traffic goes through one RAM
// with one read and one write per cycle, so shifts and linear searches move
// one entry per cycle. The table is built 16 entries deep. The capacity
// register is written through its own port; the user is to write it only
// while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_table_engine
  import ate_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ate_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ate_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_OP    = 11'b000_0000_0010,
    S_SHIFT = 11'b000_0000_0100,
    S_PUT   = 11'b000_0000_1000,
    S_DEL   = 11'b000_0001_0000,
    S_GET   = 11'b000_0010_0000,
    S_BSREQ = 11'b000_0100_0000,
    S_BSCMP = 11'b000_1000_0000,
    S_LSRCH = 11'b001_0000_0000,
    S_SWAP  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           used_q, used_d;
  logic [CAP_W-1:0]        cap_q, cap_d;
  logic                    out_valid_q, out_valid_d;
  ate_out_t                out_data_q, out_data_d;

  op_e                     op_q, op_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [AW-1:0]           a_q, a_d;
  logic [AW-1:0]           p_q, p_d;
  logic signed [SW-1:0]    lo_q, lo_d;
  logic signed [SW-1:0]    hi_q, hi_d;
  logic [VAL_W-1:0]        prev_q, prev_d;
  logic                    first_q, first_d;
  logic                    sorted_q, sorted_d;
  stat_e                   status_q, status_d;
  logic signed [VAL_W-1:0] rd_q, rd_d;
  logic [AW-1:0]           fidx_q, fidx_d;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  logic [LW-1:0]           lim;
  logic                    full;
  logic                    pos_gt_n;
  logic                    pos_eq_n;
  logic [AW-1:0]           nm1;
  logic [AW-1:0]           pidx;
  logic [SW:0]             mid_sum;
  logic [AW-1:0]           mid;
  logic                    move;
  logic [AW-1:0]           stop;
  logic                    in_acc;

  ate_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign lim      = (LW'(cap_q) < LW'(DEPTH)) ? LW'(cap_q) : LW'(DEPTH);
  assign full     = (LW'(used_q) >= lim);
  assign pos_gt_n = (PW'(pos_q) > PW'(used_q));
  assign pos_eq_n = (PW'(pos_q) == PW'(used_q));
  assign nm1      = AW'(used_q - CW'(1));
  assign pidx     = AW'(pos_q);
  assign mid_sum  = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
  assign mid      = mid_sum[AW:1];
  assign move     = !sorted_q || ($signed(ram_rdata) > val_q);
  assign stop     = sorted_q ? '0 : pidx;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    a_d         = a_q;
    p_d         = p_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    prev_d      = prev_q;
    first_d     = first_q;
    sorted_d    = sorted_q;
    status_d    = status_q;
    rd_d        = rd_q;
    fidx_d      = fidx_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d     = in_data_i.op;
          pos_d    = in_data_i.position;
          val_d    = in_data_i.operand;
          status_d = STAT_OK;
          rd_d     = '0;
          fidx_d   = '0;
          state_d  = S_OP;
        end
      end

      S_OP: begin
        state_d = S_FIN;
        case (op_q)
          OP_APPEND: begin
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(used_q);
              ram_wdata = val_q;
              used_d    = used_q + CW'(1);
            end
          end
          OP_INSERT: begin
            if (pos_gt_n) begin
              status_d = STAT_BADIDX;
            end else if (full) begin
              status_d = STAT_FULL;
            end else if (pos_eq_n) begin
              p_d     = pidx;
              state_d = S_PUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = nm1;
              a_d       = nm1;
              sorted_d  = 1'b0;
              state_d   = S_SHIFT;
            end
          end
          OP_SORTED: begin
            if (full) begin
              status_d = STAT_FULL;
            end else if (used_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = val_q;
              used_d    = used_q + CW'(1);
            end else begin
              ram_re    = 1'b1;
              ram_raddr = nm1;
              a_d       = nm1;
              sorted_d  = 1'b1;
              state_d   = S_SHIFT;
            end
          end
          OP_DELETE: begin
            if (pos_gt_n || pos_eq_n) begin
              status_d = STAT_BADIDX;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = pidx;
              a_d       = pidx;
              first_d   = 1'b1;
              state_d   = S_DEL;
            end
          end
          OP_GET: begin
            if (pos_gt_n || pos_eq_n) begin
              status_d = STAT_BADIDX;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = pidx;
              state_d   = S_GET;
            end
          end
          OP_SET: begin
            if (pos_gt_n || pos_eq_n) begin
              status_d = STAT_BADIDX;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pidx;
              ram_wdata = val_q;
            end
          end
          OP_BSEARCH: begin
            status_d = STAT_NOTFOUND;
            lo_d     = '0;
            hi_d     = SW'(used_q) - SW'(1);
            state_d  = S_BSREQ;
          end
          OP_LSEARCH: begin
            status_d = STAT_NOTFOUND;
            if (used_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              a_d       = '0;
              prev_d    = '0;
              state_d   = S_LSRCH;
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = a_q + AW'(1);
        if (move) begin
          ram_wdata = ram_rdata;
          if (a_q == stop) begin
            p_d     = a_q;
            state_d = S_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = a_q - AW'(1);
            a_d       = a_q - AW'(1);
          end
        end else begin
          ram_wdata = val_q;
          used_d    = used_q + CW'(1);
          state_d   = S_FIN;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = val_q;
        used_d    = used_q + CW'(1);
        state_d   = S_FIN;
      end

      S_DEL: begin
        first_d = 1'b0;
        if (first_q) begin
          rd_d = $signed(ram_rdata);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = a_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (a_q == nm1) begin
          used_d  = used_q - CW'(1);
          state_d = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = a_q + AW'(1);
          a_d       = a_q + AW'(1);
        end
      end

      S_GET: begin
        rd_d    = $signed(ram_rdata);
        state_d = S_FIN;
      end

      S_BSREQ: begin
        if (lo_q > hi_q) begin
          state_d = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = mid;
          a_d       = mid;
          state_d   = S_BSCMP;
        end
      end

      S_BSCMP: begin
        if ($signed(ram_rdata) == val_q) begin
          status_d = STAT_OK;
          rd_d     = val_q;
          fidx_d   = a_q;
          state_d  = S_FIN;
        end else if (val_q < $signed(ram_rdata)) begin
          hi_d    = SW'(a_q) - SW'(1);
          state_d = S_BSREQ;
        end else begin
          lo_d    = SW'(a_q) + SW'(1);
          state_d = S_BSREQ;
        end
      end

      S_LSRCH: begin
        if (ram_rdata == val_q) begin
          status_d = STAT_OK;
          rd_d     = val_q;
          if (a_q == '0) begin
            state_d = S_FIN;
          end else begin
            // move the predecessor up, the key goes one place down
            ram_we    = 1'b1;
            ram_waddr = a_q;
            ram_wdata = prev_q;
            fidx_d    = a_q - AW'(1);
            state_d   = S_SWAP;
          end
        end else begin
          prev_d = ram_rdata;
          if (a_q == nm1) begin
            state_d = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = a_q + AW'(1);
            a_d       = a_q + AW'(1);
          end
        end
      end

      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = a_q - AW'(1);
        ram_wdata = val_q;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.read_value  = rd_q;
          out_data_d.found_index = FIDX_W'(fidx_q);
          out_data_d.count       = COUNT_W'(used_q);
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      cap_q       <= CAP_W'(DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    op_q       <= op_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    a_q        <= a_d;
    p_q        <= p_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    prev_q     <= prev_d;
    first_q    <= first_d;
    sorted_q   <= sorted_d;
    status_q   <= status_d;
    rd_q       <= rd_d;
    fidx_q     <= fidx_d;
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_OP)
    else $error("accepted item not decoded next cycle");

  a_used_at_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> state_q == S_FIN)
    else $error("entry count changed outside request completion");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && status_q == STAT_FULL) |-> $stable(used_q))
    else $error("refused insert changed the entry count");

endmodule

[rtl/core/ate_ram.sv]
// ----------------------------------------------------------------------------
// ate_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/array_table_engine_tb.sv]
// ----------------------------------------------------------------------------
// array_table_engine_tb
// Self-checking bench for the array table engine. A short scripted sequence
// walks the empty table, index and full refusals, transposition and sorted
// inserts, then random requests run in twelve segments with different
// capacities, idle patterns on both channels and sorted-table stretches for
// binary search. Every result must match a scripted want or the table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_table_engine_tb;
  import ate_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 136;
  localparam int MAX_REPORTS  = 10;
  localparam int SEG_CAPS [SEGMENTS] = '{16, 16, 0, 12, 3, 16, 1, 9, 16, 5, 7, 16};

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CHECKED,
    ROW_CAP
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    ate_in_t            req;
    ate_out_t           want;
    logic [CAP_W-1:0]   cap;
  } script_row_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  ate_in_t          in_data     = '0;
  logic             out_stall   = 1'b0;
  logic             cfg_valid   = 1'b0;
  logic [CAP_W-1:0] cfg_data    = '0;
  logic             in_stall;
  logic             out_valid;
  ate_out_t         out_data;
  logic             cfg_ready;

  // table model
  logic signed [VAL_W-1:0] tbl [DEPTH];
  int                      row_count = 0;
  int                      cap_reg   = DEPTH;

  ate_out_t    pending_results [$];
  script_row_t script [$];

  int send_idle_pct = 28;
  int recv_idle_pct = 45;
  int bad_results   = 0;
  int cycle_count   = 0;
  int caps_written  = 0;
  int requests_sent = 0;
  int op_seen [8];
  int status_seen [4];

  array_table_engine i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic ate_out_t apply_request(ate_in_t req);
    ate_out_t                res;
    int                      lim;
    int                      lo;
    int                      hi;
    int                      mid;
    int                      k;
    bit                      full;
    bit                      hit;
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] swap_val;
    res = '0;
    res.status = STAT_OK;
    key = req.operand;
    lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    full = (row_count >= lim);
    hit = 1'b0;
    case (req.op)
      OP_APPEND: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          tbl[row_count] = key;
          row_count++;
        end
      end
      OP_INSERT: begin
        if (int'(req.position) > row_count) begin
          res.status = STAT_BADIDX;
        end else if (full) begin
          res.status = STAT_FULL;
        end else begin
          for (k = row_count; k > int'(req.position); k--) tbl[k] = tbl[k-1];
          tbl[req.position] = key;
          row_count++;
        end
      end
      OP_DELETE: begin
        if (int'(req.position) >= row_count) begin
          res.status = STAT_BADIDX;
        end else begin
          res.read_value = tbl[req.position];
          for (k = int'(req.position); k + 1 < row_count; k++) tbl[k] = tbl[k+1];
          row_count--;
        end
      end
      OP_GET: begin
        if (int'(req.position) >= row_count) res.status = STAT_BADIDX;
        else res.read_value = tbl[req.position];
      end
      OP_SET: begin
        if (int'(req.position) >= row_count) res.status = STAT_BADIDX;
        else tbl[req.position] = key;
      end
      OP_SORTED: begin
        if (full) begin
          res.status = STAT_FULL;
        end else begin
          k = row_count;
          while (k > 0 && tbl[k-1] > key) begin
            tbl[k] = tbl[k-1];
            k--;
          end
          tbl[k] = key;
          row_count++;
        end
      end
      OP_BSEARCH: begin
        res.status = STAT_NOTFOUND;
        lo = 0;
        hi = row_count - 1;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (tbl[mid] == key) begin
            hit = 1'b1;
            res.status = STAT_OK;
            res.read_value = key;
            res.found_index = mid[FIDX_W-1:0];
          end else if (key < tbl[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: begin
        res.status = STAT_NOTFOUND;
        for (k = 0; k < row_count && !hit; k++) begin
          if (tbl[k] == key) begin
            hit = 1'b1;
            res.status = STAT_OK;
            res.read_value = key;
            if (k > 0) begin
              swap_val = tbl[k];
              tbl[k] = tbl[k-1];
              tbl[k-1] = swap_val;
              res.found_index = 4'(k - 1);
            end
          end
        end
      end
    endcase
    res.count = row_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic ate_in_t make_req(op_e op, int pos, logic signed [VAL_W-1:0] val);
    ate_in_t req;
    req.op = op;
    req.position = pos[POS_W-1:0];
    req.operand = val;
    return req;
  endfunction

  function automatic script_row_t plain_row(op_e op, int pos, logic signed [VAL_W-1:0] val);
    script_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.req = make_req(op, pos, val);
    return row;
  endfunction

  function automatic script_row_t checked_row(op_e op, int pos, logic signed [VAL_W-1:0] val,
                                              stat_e st, logic signed [VAL_W-1:0] rd,
                                              int fidx, int cnt);
    script_row_t row;
    row = plain_row(op, pos, val);
    row.kind = ROW_CHECKED;
    row.want.status = st;
    row.want.read_value = rd;
    row.want.found_index = fidx[FIDX_W-1:0];
    row.want.count = cnt[COUNT_W-1:0];
    return row;
  endfunction

  function automatic script_row_t cap_row(int cap);
    script_row_t row;
    row = '0;
    row.kind = ROW_CAP;
    row.cap = cap[CAP_W-1:0];
    return row;
  endfunction

  function automatic logic signed [VAL_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (row_count > 0) return tbl[$urandom_range(0, row_count - 1)];
        return $urandom;
      end
      4, 5: return 32'($urandom_range(0, 8)) - 32'd4;
      6: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic ate_in_t random_request(bit keep_sorted);
    ate_in_t req;
    int      pick;
    pick = $urandom_range(0, 99);
    if (keep_sorted && pick < 90) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) req.op = OP_SORTED;
      else if (pick < 55) req.op = OP_DELETE;
      else if (pick < 65) req.op = OP_GET;
      else req.op = OP_BSEARCH;
    end else begin
      req.op = op_e'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) < 7) req.position = POS_W'($urandom_range(0, row_count));
    else req.position = POS_W'($urandom_range(0, 255));
    req.operand = random_operand();
    return req;
  endfunction

  task automatic send_request(input ate_in_t req, input bit typed, input ate_out_t want);
    ate_out_t model;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = apply_request(req);
    pending_results.push_back(typed ? want : model);
    op_seen[req.op]++;
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = int'(cap);
    caps_written++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    ate_out_t want;
    ate_out_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      status_seen[int'(got.status)]++;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result item: status %0d value %0d index %0d count %0d",
                   got.status, got.read_value, got.found_index, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.read_value !== want.read_value ||
            got.found_index !== want.found_index || got.count !== want.count) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("mismatch: status %0d/%0d value %0d/%0d index %0d/%0d count %0d/%0d",
                     want.status, got.status, want.read_value, got.read_value,
                     want.found_index, got.found_index, want.count, got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    script = '{
      cap_row(16),
      checked_row(OP_GET,     0,   5,       STAT_BADIDX,   0,       0, 0),
      checked_row(OP_BSEARCH, 0,   5,       STAT_NOTFOUND, 0,       0, 0),
      checked_row(OP_LSEARCH, 0,   5,       STAT_NOTFOUND, 0,       0, 0),
      checked_row(OP_DELETE,  0,   0,       STAT_BADIDX,   0,       0, 0),
      checked_row(OP_APPEND,  255, VAL_MAX, STAT_OK,       0,       0, 1),
      checked_row(OP_APPEND,  0,   VAL_MIN, STAT_OK,       0,       0, 2),
      checked_row(OP_INSERT,  3,   9,       STAT_BADIDX,   0,       0, 2),
      plain_row(OP_INSERT,    0,   -1),
      plain_row(OP_INSERT,    3,   7),
      checked_row(OP_SET,     255, 1,       STAT_BADIDX,   0,       0, 4),
      checked_row(OP_SET,     1,   100,     STAT_OK,       0,       0, 4),
      checked_row(OP_GET,     2,   0,       STAT_OK,       VAL_MIN, 0, 4),
      checked_row(OP_LSEARCH, 0,   -1,      STAT_OK,       -1,      0, 4),
      checked_row(OP_LSEARCH, 0,   7,       STAT_OK,       7,       2, 4),
      checked_row(OP_DELETE,  3,   0,       STAT_OK,       VAL_MIN, 0, 3),
      plain_row(OP_DELETE,    0,   0),
      plain_row(OP_DELETE,    0,   0),
      plain_row(OP_SORTED,    0,   3),
      plain_row(OP_SORTED,    0,   7),
      plain_row(OP_SORTED,    0,   VAL_MIN),
      plain_row(OP_BSEARCH,   0,   3),
      plain_row(OP_BSEARCH,   0,   7),
      checked_row(OP_BSEARCH, 0,   VAL_MAX, STAT_NOTFOUND, 0,       0, 4),
      cap_row(2),
      checked_row(OP_APPEND,  0,   1,       STAT_FULL,     0,       0, 4),
      checked_row(OP_INSERT,  5,   1,       STAT_BADIDX,   0,       0, 4),
      checked_row(OP_INSERT,  0,   9,       STAT_FULL,     0,       0, 4),
      checked_row(OP_SORTED,  0,   0,       STAT_FULL,     0,       0, 4),
      plain_row(OP_DELETE,    3,   0),
      cap_row(0),
      checked_row(OP_APPEND,  0,   1,       STAT_FULL,     0,       0, 3)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CAP) write_capacity(script[i].cap);
      else send_request(script[i].req, script[i].kind == ROW_CHECKED, script[i].want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 45;
      end else if (seg < 8) begin
        send_idle_pct = 45;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(CAP_W'(SEG_CAPS[seg]));
      // odd segments rebuild a sorted table for binary search
      if (seg % 2 == 1) begin
        while (row_count > 0) send_request(make_req(OP_DELETE, 0, 0), 1'b0, '0);
      end
      repeat (SEG_ITEMS) send_request(random_request(seg % 2 == 1), 1'b0, '0);
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("covered %0d requests under %0d capacity writes and three idle patterns",
             requests_sent, caps_written);
    $display("ops app %0d ins %0d del %0d get %0d set %0d srt %0d bs %0d ls %0d; %s %0d %0d %0d %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6], op_seen[7], "status ok/idx/full/miss", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (bad_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failing result items", bad_results);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[array_table_engine.f]
rtl/core/ate_pkg.sv
rtl/core/ate_ram.sv
rtl/core/array_table_engine.sv
tb/array_table_engine_tb.sv
